// File: hdl/rrs_pkg.sv
// Shared types and opcode constants for the RIP-relative reference scanner.
package rrs_pkg;

    localparam logic [7:0] OP_REX_W     = 8'h48;
    localparam logic [7:0] OP_REX_WR    = 8'h4C;
    localparam logic [7:0] OP_REX_WB    = 8'h49;
    localparam logic [7:0] OP_LEA       = 8'h8D;
    localparam logic [7:0] OP_MOV_LOAD  = 8'h8B;
    localparam logic [7:0] OP_MOV_STORE = 8'h89;
    localparam logic [7:0] OP_ESCAPE    = 8'h0F;
    localparam logic [7:0] OP_MOVAPS    = 8'h28;
    localparam logic [7:0] OP_MOVUPS_LD = 8'h10;
    localparam logic [7:0] OP_MOVUPS_ST = 8'h11;
    localparam logic [7:0] OP_MOVDQ_LD  = 8'h6F;
    localparam logic [7:0] OP_MOVDQ_ST  = 8'h7F;
    localparam logic [7:0] PFX_OPSIZE   = 8'h66;
    localparam logic [7:0] PFX_REP      = 8'hF3;
    localparam logic [7:0] MODRM_MASK   = 8'hC7;
    localparam logic [7:0] MODRM_RIP    = 8'h05;

    localparam int WIN_DEPTH = 8;
    localparam int CFG_W     = 33;
    localparam int START_W   = 32;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       end_of_image;
    } item_t;

    typedef struct packed {
        logic               found;
        logic [START_W-1:0] ref_start;
        logic               scan_done;
    } result_t;

    // One classified byte, handed from the front end to the back end.
    typedef struct packed {
        logic               hit;
        logic [START_W-1:0] start;
        logic               last;
    } tok_t;

endpackage

// File: hdl/rip_relative_reference_scanner.sv
// Top level of the RIP-relative reference scanner.
// Takes one image byte per cycle through item/push while not full, and reports
// each confirmed reference (LEA/MOV/SSE load-store with a [rip+disp32] operand
// landing on target_offset) as a result with found set and ref_start holding
// the offset of the instruction's first byte. A hit is reported when the byte
// eight past its displacement start arrives; hits in the last 8 bytes are
// dropped. The final byte (end_of_image) always produces a result with
// scan_done set, and the scan state clears after it. Throughput is one byte
// per cycle while no queue is full: the front end classifies a byte in its
// transfer cycle, a token queue carries it to the back end, which steps its
// confirmation line per token. Users must write target_offset through
// cfg_wr/cfg_data only while the scanner is idle; the block does not check it.
module rip_relative_reference_scanner #(
    parameter int OFFSET_BITS = 32,
    parameter int CONFIRM_LAG = 5,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr,
    input  logic signed [rrs_pkg::CFG_W-1:0]  cfg_data,
    input  logic                              push,
    input  rrs_pkg::item_t                    item,
    output logic                              full,
    input  logic                              pop,
    output rrs_pkg::result_t                  result,
    output logic                              empty
);
    import rrs_pkg::*;

    logic signed [CFG_W-1:0] target_reg;
    logic                    accept;
    tok_t                    tok_in, tok_out;
    logic                    tok_empty, tok_pop;
    logic                    res_full, res_push;
    result_t                 res;

    assign accept = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
        end
        else if (cfg_wr)
        begin
            target_reg <= cfg_data;
        end
    end

    rrs_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .target (target_reg),
        .accept (accept),
        .item   (item),
        .tok    (tok_in)
    );

    rrs_fifo #(
        .WIDTH ($bits(tok_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_tok_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (tok_in),
        .full  (full),
        .pop   (tok_pop),
        .rdata (tok_out),
        .empty (tok_empty)
    );

    rrs_back #(
        .CONFIRM_LAG (CONFIRM_LAG)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_avail (!tok_empty),
        .tok       (tok_out),
        .tok_pop   (tok_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res)
    );

    rrs_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res),
        .full  (res_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule

// File: hdl/rrs_fifo.sv
// Small register queue with fill count.
module rrs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: hdl/rrs_front.sv
// Front end: byte window, offset counter and candidate classification.
module rrs_front #(
    parameter int OFFSET_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic signed [rrs_pkg::CFG_W-1:0]    target,
    input  logic                                accept,
    input  rrs_pkg::item_t                      item,
    output rrs_pkg::tok_t                       tok
);
    import rrs_pkg::*;

    localparam int AW = ((OFFSET_BITS > CFG_W) ? OFFSET_BITS : CFG_W) + 2;

    logic [7:0]             win_reg [WIN_DEPTH];
    logic [7:0]             win_next [WIN_DEPTH];
    logic [OFFSET_BITS-1:0] pos_reg;
    logic [OFFSET_BITS-1:0] cand;
    logic [OFFSET_BITS-1:0] start;
    logic [31:0]            disp;
    logic [AW-1:0]          addr;
    logic [AW-1:0]          tgt_ext;
    logic [7:0]             modrm, op, pre, pre2;
    logic                   pre_rex, pre_adj, pre2_adj, form_ok, hit;

    always_comb
    begin
        for (int k = 0; k < WIN_DEPTH - 1; k++)
        begin
            win_next[k] = win_reg[k + 1];
        end
        win_next[WIN_DEPTH - 1] = item.code_byte;
    end

    // Candidate disp32 ends at the newest byte; it starts at pos - 3.
    assign cand    = pos_reg - OFFSET_BITS'(3);
    assign disp    = {win_next[7], win_next[6], win_next[5], win_next[4]};
    assign addr    = {{(AW - OFFSET_BITS){1'b0}}, cand} + AW'(4)
                   + {{(AW - 32){disp[31]}}, disp};
    assign tgt_ext = {{(AW - CFG_W){target[CFG_W-1]}}, target};

    assign modrm = win_next[3];
    assign op    = win_next[2];
    assign pre   = win_next[1];
    assign pre2  = win_next[0];

    assign pre_rex  = (pre == OP_REX_W) || (pre == OP_REX_WR) || (pre == OP_REX_WB);
    assign pre_adj  = pre_rex || (pre == OP_ESCAPE);
    assign pre2_adj = (pre2 == PFX_OPSIZE) || (pre2 == PFX_REP);

    always_comb
    begin
        form_ok = 1'b0;
        if (pre_rex && (op == OP_LEA || op == OP_MOV_LOAD))
        begin
            form_ok = 1'b1;
        end
        if (op == OP_MOV_LOAD || op == OP_MOV_STORE)
        begin
            form_ok = 1'b1;
        end
        if (pre == OP_ESCAPE
            && (op == OP_MOVAPS || op == OP_MOVUPS_LD || op == OP_MOVUPS_ST))
        begin
            form_ok = 1'b1;
        end
        if (pre2 == PFX_OPSIZE && pre == OP_ESCAPE
            && (op == OP_MOVAPS || op == OP_MOVDQ_LD || op == OP_MOVDQ_ST))
        begin
            form_ok = 1'b1;
        end
        if (pre2 == PFX_REP && pre == OP_ESCAPE
            && (op == OP_MOVDQ_LD || op == OP_MOVDQ_ST || op == OP_MOVUPS_LD))
        begin
            form_ok = 1'b1;
        end
    end

    assign hit = (pos_reg >= OFFSET_BITS'(5)) && (addr == tgt_ext)
              && ((modrm & MODRM_MASK) == MODRM_RIP) && form_ok;

    assign start = cand - OFFSET_BITS'(2) - OFFSET_BITS'(pre_adj)
                 - OFFSET_BITS'(pre2_adj);

    assign tok.hit   = hit;
    assign tok.start = START_W'(start);
    assign tok.last  = item.end_of_image;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < WIN_DEPTH; k++)
            begin
                win_reg[k] <= '0;
            end
            pos_reg <= '0;
        end
        else if (accept)
        begin
            if (item.end_of_image)
            begin
                for (int k = 0; k < WIN_DEPTH; k++)
                begin
                    win_reg[k] <= '0;
                end
                pos_reg <= '0;
            end
            else
            begin
                for (int k = 0; k < WIN_DEPTH; k++)
                begin
                    win_reg[k] <= win_next[k];
                end
                pos_reg <= pos_reg + 1'b1;
            end
        end
    end

endmodule

// File: hdl/rrs_back.sv
// Back end: confirmation delay line and result generation.
module rrs_back #(
    parameter int CONFIRM_LAG = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tok_avail,
    input  rrs_pkg::tok_t     tok,
    output logic              tok_pop,
    input  logic              res_full,
    output logic              res_push,
    output rrs_pkg::result_t  res
);
    import rrs_pkg::*;

    logic               pend_valid_reg [CONFIRM_LAG];
    logic [START_W-1:0] pend_start_reg [CONFIRM_LAG];
    logic               conf_valid;
    logic               step;

    assign conf_valid = pend_valid_reg[CONFIRM_LAG - 1];
    assign step       = tok_avail && !res_full;
    assign tok_pop    = step;
    assign res_push   = step && (conf_valid || tok.last);

    assign res.found     = conf_valid;
    assign res.ref_start = conf_valid ? pend_start_reg[CONFIRM_LAG - 1] : '0;
    assign res.scan_done = tok.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CONFIRM_LAG; k++)
            begin
                pend_valid_reg[k] <= 1'b0;
            end
        end
        else if (step)
        begin
            if (tok.last)
            begin
                for (int k = 0; k < CONFIRM_LAG; k++)
                begin
                    pend_valid_reg[k] <= 1'b0;
                end
            end
            else
            begin
                for (int k = CONFIRM_LAG - 1; k > 0; k--)
                begin
                    pend_valid_reg[k] <= pend_valid_reg[k - 1];
                end
                pend_valid_reg[0] <= tok.hit;
            end
        end
    end

    // Start offsets only matter where the matching valid bit is set.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            for (int k = CONFIRM_LAG - 1; k > 0; k--)
            begin
                pend_start_reg[k] <= pend_start_reg[k - 1];
            end
            pend_start_reg[0] <= tok.start;
        end
    end

endmodule

// File: bench/rip_relative_reference_scanner_test.sv
// Self-checking testbench for the RIP-relative reference scanner.
module rip_relative_reference_scanner_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rrs_pkg::*;

    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 140;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [7:0] code;
        logic       eoi;
        logic       typed;
        result_t    want;
    } stim_row_t;

    // Target is zero after reset. The first image is a single byte; the second has a REX LEA at
    // offset 0 whose displacement lands on zero; it is confirmed by the final byte. The third
    // is an F3 0F form whose hit needs one byte more than the image has.
    localparam stim_row_t DIRECTED_ROWS [25] = '{
        '{8'hFF, 1'b1, 1'b1, '{1'b0, 32'd0, 1'b1}},
        '{8'h48, 1'b0, 1'b0, '0},
        '{8'h8D, 1'b0, 1'b0, '0},
        '{8'h05, 1'b0, 1'b0, '0},
        '{8'hF9, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b1, 1'b1, '{1'b1, 32'd0, 1'b1}},
        '{8'hF3, 1'b0, 1'b0, '0},
        '{8'h0F, 1'b0, 1'b0, '0},
        '{8'h6F, 1'b0, 1'b0, '0},
        '{8'h05, 1'b0, 1'b0, '0},
        '{8'hF8, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b1, 1'b1, '{1'b0, 32'd0, 1'b1}}
    };

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_wr;
    logic signed [CFG_W-1:0] cfg_data;
    logic                    push;
    item_t                   item;
    logic                    full;
    logic                    pop;
    result_t                 result;
    logic                    empty;

    // scanner model state
    logic signed [CFG_W-1:0] model_target;
    logic [7:0]              model_window [WIN_DEPTH];
    logic [START_W-1:0]      model_position;
    logic                    confirm_valid [5];
    logic [START_W-1:0]      confirm_start [5];

    result_t    expected_refs [$];
    logic [7:0] image_bytes [$];
    int         mismatch_count = 0;
    bit         calm = 0;
    bit         stall_asked = 0;

    rip_relative_reference_scanner i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr   (cfg_wr),
        .cfg_data (cfg_data),
        .push     (push),
        .item     (item),
        .full     (full),
        .pop      (pop),
        .result   (result),
        .empty    (empty)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic bit is_rex(input logic [7:0] b);
        return b == OP_REX_W || b == OP_REX_WR || b == OP_REX_WB;
    endfunction

    function automatic void clear_scan();
        for (int k = 0; k < WIN_DEPTH; k++) model_window[k] = 8'h00;
        for (int k = 0; k < 5; k++)
        begin
            confirm_valid[k] = 1'b0;
            confirm_start[k] = '0;
        end
        model_position = '0;
    endfunction

    // Advances the model by one byte; returns 1 when the byte causes a result.
    function automatic bit scan_predict(input logic [7:0] b, input logic eoi,
                                        output result_t r);
        logic               cv;
        logic [START_W-1:0] cs;
        logic               hit;
        logic [START_W-1:0] st;
        logic [31:0]        raw;
        longint             disp;
        longint             addr;
        logic [7:0]         modrm, op, pre, pre2;
        bit                 form_ok;
        cv = confirm_valid[4];
        cs = confirm_start[4];
        for (int k = 0; k < WIN_DEPTH - 1; k++) model_window[k] = model_window[k + 1];
        model_window[WIN_DEPTH - 1] = b;
        hit = 1'b0;
        st = '0;
        if (model_position >= 5)
        begin
            raw = {model_window[7], model_window[6], model_window[5], model_window[4]};
            disp = longint'($signed(raw));
            addr = longint'(model_position) + 1 + disp;
            modrm = model_window[3];
            op = model_window[2];
            pre = model_window[1];
            pre2 = model_window[0];
            form_ok = (is_rex(pre) && (op == OP_LEA || op == OP_MOV_LOAD))
                || op == OP_MOV_LOAD || op == OP_MOV_STORE
                || (pre == OP_ESCAPE && (op == OP_MOVAPS || op == OP_MOVUPS_LD
                                         || op == OP_MOVUPS_ST))
                || (pre2 == PFX_OPSIZE && pre == OP_ESCAPE
                    && (op == OP_MOVAPS || op == OP_MOVDQ_LD || op == OP_MOVDQ_ST))
                || (pre2 == PFX_REP && pre == OP_ESCAPE
                    && (op == OP_MOVDQ_LD || op == OP_MOVDQ_ST || op == OP_MOVUPS_LD));
            if (addr == longint'(model_target) && (modrm & MODRM_MASK) == MODRM_RIP
                && form_ok)
            begin
                hit = 1'b1;
                // start sits two below the displacement, less any prefixes
                st = model_position - 5;
                if (is_rex(pre) || pre == OP_ESCAPE) st = st - 1;
                if (pre2 == PFX_OPSIZE || pre2 == PFX_REP) st = st - 1;
            end
        end
        for (int k = 4; k > 0; k--)
        begin
            confirm_valid[k] = confirm_valid[k - 1];
            confirm_start[k] = confirm_start[k - 1];
        end
        confirm_valid[0] = hit;
        confirm_start[0] = st;
        model_position = model_position + 1;
        r = '{found: cv, ref_start: cv ? cs : '0, scan_done: eoi};
        if (eoi) clear_scan();
        return cv || eoi;
    endfunction

    function automatic logic [7:0] pick_rex();
        case ($urandom_range(2))
            0: return OP_REX_W;
            1: return OP_REX_WR;
            default: return OP_REX_WB;
        endcase
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        image_bytes.insert(image_bytes.size(), b);
    endfunction

    // Random image: noise mixed with reference forms aimed at the current target.
    task automatic build_image();
        int         len;
        longint     disp;
        logic [7:0] modrm;
        logic [31:0] d32;
        image_bytes.delete();
        len = ($urandom_range(7) == 0) ? $urandom_range(1, 9) : $urandom_range(10, 70);
        while (image_bytes.size() < len)
        begin
            if ($urandom_range(99) < 45)
            begin
                repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
            end
            else
            begin
                case ($urandom_range(4))
                    0:
                    begin
                        if ($urandom_range(3) == 0)
                            add_byte($urandom_range(1) ? PFX_OPSIZE : PFX_REP);
                        add_byte(pick_rex());
                        add_byte($urandom_range(1) ? OP_LEA : OP_MOV_LOAD);
                    end
                    1:
                    begin
                        case ($urandom_range(5))
                            0: add_byte(pick_rex());
                            1: add_byte(OP_ESCAPE);
                            2: add_byte(PFX_OPSIZE);
                            3: add_byte(PFX_REP);
                            4: add_byte(8'($urandom));
                            default: ;
                        endcase
                        add_byte($urandom_range(1) ? OP_MOV_LOAD : OP_MOV_STORE);
                    end
                    2:
                    begin
                        add_byte(OP_ESCAPE);
                        case ($urandom_range(2))
                            0: add_byte(OP_MOVAPS);
                            1: add_byte(OP_MOVUPS_LD);
                            default: add_byte(OP_MOVUPS_ST);
                        endcase
                    end
                    3:
                    begin
                        add_byte(PFX_OPSIZE);
                        add_byte(OP_ESCAPE);
                        case ($urandom_range(2))
                            0: add_byte(OP_MOVAPS);
                            1: add_byte(OP_MOVDQ_LD);
                            default: add_byte(OP_MOVDQ_ST);
                        endcase
                    end
                    default:
                    begin
                        add_byte(PFX_REP);
                        add_byte(OP_ESCAPE);
                        case ($urandom_range(2))
                            0: add_byte(OP_MOVDQ_LD);
                            1: add_byte(OP_MOVDQ_ST);
                            default: add_byte(OP_MOVUPS_LD);
                        endcase
                    end
                endcase
                modrm = MODRM_RIP | 8'($urandom_range(7) << 3);
                if ($urandom_range(9) == 0) modrm = 8'($urandom);
                add_byte(modrm);
                disp = longint'(model_target) - longint'(image_bytes.size()) - 4;
                if ($urandom_range(9) == 0) disp = disp + $urandom_range(1, 3);
                if (disp < -longint'(64'h8000_0000) || disp > longint'(64'h7FFF_FFFF))
                    disp = longint'($urandom);
                d32 = disp[31:0];
                for (int k = 0; k < 4; k++) add_byte(d32[8*k +: 8]);
            end
        end
        while (image_bytes.size() > len) void'(image_bytes.pop_back());
    endtask

    // Offers one byte and waits for its transfer; entered and left at a falling edge.
    task automatic send_byte(input logic [7:0] b, input logic eoi, input bit typed,
                             input result_t want);
        result_t r;
        bit      has;
        while (!calm && $urandom_range(99) < 34)
        begin
            push = 1'b0;
            @(negedge clk);
        end
        push = 1'b1;
        item = '{code_byte: b, end_of_image: eoi};
        @(posedge clk);
        while (full) @(posedge clk);
        has = scan_predict(b, eoi, r);
        if (typed)
            expected_refs.insert(expected_refs.size(), want);
        else if (has)
            expected_refs.insert(expected_refs.size(), r);
        @(negedge clk);
    endtask

    task automatic drain();
        push = 1'b0;
        wait (expected_refs.size() == 0);
        @(negedge clk);
    endtask

    task automatic write_target(input logic signed [CFG_W-1:0] value);
        drain();
        repeat (6) @(negedge clk);
        cfg_wr = 1'b1;
        cfg_data = value;
        model_target = value;
        @(negedge clk);
        cfg_wr = 1'b0;
    endtask

    initial
    begin
        int sent;
        logic signed [CFG_W-1:0] next_target;
        rst_n = 1'b0;
        cfg_wr = 1'b0;
        cfg_data = '0;
        push = 1'b0;
        item = '0;
        model_target = '0;
        clear_scan();
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        foreach (DIRECTED_ROWS[n])
            send_byte(DIRECTED_ROWS[n].code, DIRECTED_ROWS[n].eoi, DIRECTED_ROWS[n].typed,
                      DIRECTED_ROWS[n].want);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: next_target = CFG_W'($urandom_range(0, 300));
                1: next_target = {1'b1, 32'h0000_0000};
                2: next_target = {1'b0, 32'hFFFF_FFFF};
                3: next_target = -CFG_W'($urandom_range(1, 200));
                5, 6: next_target = {1'($urandom), 32'($urandom)};
                default: next_target = CFG_W'($signed(32'($urandom_range(0, 2097151))
                                                      - 32'sd1048576));
            endcase
            write_target(next_target);
            calm = (phase == 3);
            if (phase == 4) stall_asked = 1'b1;
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                build_image();
                foreach (image_bytes[n])
                    send_byte(image_bytes[n], n == image_bytes.size() - 1, 1'b0, '0);
                sent += image_bytes.size();
                if ($urandom_range(5) == 0) drain();
            end
        end
        calm = 1'b0;

        drain();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // result side: random pop (steady while calm), one long hold-off on request
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_asked)
            begin
                stall_asked = 1'b0;
                pop = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            pop = calm ? 1'b1 : ($urandom_range(99) >= 34);
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_refs.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected transfer found=%0b ref_start=%h scan_done=%0b",
                         $realtime, result.found, result.ref_start, result.scan_done);
            end
            else
            begin
                want = expected_refs.pop_front();
                if (result.found !== want.found)
                begin
                    mismatch_count++;
                    $display("%0t: found expected %0b actual %0b",
                             $realtime, want.found, result.found);
                end
                if (result.ref_start !== want.ref_start)
                begin
                    mismatch_count++;
                    $display("%0t: ref_start expected %h actual %h",
                             $realtime, want.ref_start, result.ref_start);
                end
                if (result.scan_done !== want.scan_done)
                begin
                    mismatch_count++;
                    $display("%0t: scan_done expected %0b actual %0b",
                             $realtime, want.scan_done, result.scan_done);
                end
            end
        end
    end

endmodule

// File: filelist.f
hdl/rrs_pkg.sv
hdl/rrs_fifo.sv
hdl/rrs_front.sv
hdl/rrs_back.sv
hdl/rip_relative_reference_scanner.sv
bench/rip_relative_reference_scanner_test.sv
